// ----- rtl/rrr_pkg.sv -----
// shared constants, types and helpers for the reflect/refract pipeline
`default_nettype none

package rrr_pkg;

   localparam int COMP_WIDTH_DEF = 20;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int MUL_CHUNK      = 32;

   typedef enum logic {
      MODE_REFLECT = 1'b0,
      MODE_REFRACT = 1'b1
   } mode_type;

   function automatic int imax(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/rrr_if.sv -----
// request and response channel interfaces
`default_nettype none

interface rrr_req_if #(
   parameter int COMP_WIDTH = rrr_pkg::COMP_WIDTH_DEF,
   parameter int FRAC_BITS  = rrr_pkg::FRAC_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic signed [COMP_WIDTH-1:0] incident_x;
   logic signed [COMP_WIDTH-1:0] incident_y;
   logic signed [COMP_WIDTH-1:0] incident_z;
   logic signed [COMP_WIDTH-1:0] normal_x;
   logic signed [COMP_WIDTH-1:0] normal_y;
   logic signed [COMP_WIDTH-1:0] normal_z;
   logic        [FRAC_BITS+1:0]  eta_ratio;

   modport source (
      output valid, mode, incident_x, incident_y, incident_z,
             normal_x, normal_y, normal_z, eta_ratio,
      input  ready
   );
   modport sink (
      input  valid, mode, incident_x, incident_y, incident_z,
             normal_x, normal_y, normal_z, eta_ratio,
      output ready
   );
endinterface

interface rrr_rsp_if #(
   parameter int COMP_WIDTH = rrr_pkg::COMP_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COMP_WIDTH-1:0] out_x;
   logic signed [COMP_WIDTH-1:0] out_y;
   logic signed [COMP_WIDTH-1:0] out_z;

   modport source (output valid, out_x, out_y, out_z, input ready);
   modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

`default_nettype wire

// ----- rtl/rrr_mul3.sv -----
// three-lane pipelined signed multiplier, one chunk partial product per stage
`default_nettype none

module rrr_mul3 #(
   parameter int AW  = rrr_pkg::COMP_WIDTH_DEF,
   parameter int BW  = rrr_pkg::COMP_WIDTH_DEF,
   parameter int SBW = 1,
   parameter int CW  = rrr_pkg::MUL_CHUNK
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [AW-1:0]    in_a [3],
   input  logic signed [BW-1:0]    in_b [3],
   input  logic [SBW-1:0]          in_sb,
   output logic                    out_valid,
   output logic signed [AW+BW-1:0] out_p [3],
   output logic [SBW-1:0]          out_sb
);
   import rrr_pkg::*;

   localparam int NA = (AW + CW - 1) / CW;
   localparam int NB = (BW + CW - 1) / CW;
   localparam int K  = NA * NB;
   localparam int PW = AW + BW;

   logic                 valid_ff [K];
   logic [SBW-1:0]       sb_ff    [K];
   logic signed [AW-1:0] a_ff     [K][3];
   logic signed [BW-1:0] b_ff     [K][3];
   logic signed [PW-1:0] acc_ff   [K][3];

   genvar k;
   for (k = 0; k < K; k++) begin : g_stage
      localparam int JA = k / NB;
      localparam int JB = k % NB;

      logic                 valid_in;
      logic [SBW-1:0]       sb_in;
      logic signed [AW-1:0] a_in   [3];
      logic signed [BW-1:0] b_in   [3];
      logic signed [PW-1:0] acc_pv [3];
      logic signed [PW-1:0] acc_in [3];

      if (k == 0) begin : g_first
         assign valid_in = in_valid;
         assign sb_in    = in_sb;
         assign a_in     = in_a;
         assign b_in     = in_b;
         assign acc_pv   = '{default: '0};
      end else begin : g_next
         assign valid_in = valid_ff[k-1];
         assign sb_in    = sb_ff[k-1];
         assign a_in     = a_ff[k-1];
         assign b_in     = b_ff[k-1];
         assign acc_pv   = acc_ff[k-1];
      end

      always_comb begin
         logic signed [NA*CW-1:0] ap;
         logic signed [NB*CW-1:0] bp;
         logic signed [CW:0]      ca;
         logic signed [CW:0]      cb;
         logic signed [2*CW+1:0]  pp;
         for (int l = 0; l < 3; l++) begin
            ap = (NA*CW)'(a_in[l]);
            bp = (NB*CW)'(b_in[l]);
            ca = (JA == NA - 1) ? {ap[JA*CW+CW-1], ap[JA*CW +: CW]}
                                : {1'b0, ap[JA*CW +: CW]};
            cb = (JB == NB - 1) ? {bp[JB*CW+CW-1], bp[JB*CW +: CW]}
                                : {1'b0, bp[JB*CW +: CW]};
            pp = ca * cb;
            acc_in[l] = acc_pv[l] + (PW'(pp) <<< ((JA + JB) * CW));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_in;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sb_ff[k]  <= sb_in;
            a_ff[k]   <= a_in;
            b_ff[k]   <= b_in;
            acc_ff[k] <= acc_in;
         end
      end
   end

   assign out_valid = valid_ff[K-1];
   assign out_p     = acc_ff[K-1];
   assign out_sb    = sb_ff[K-1];

endmodule

`default_nettype wire

// ----- rtl/rrr_sqrt.sv -----
// pipelined floor square root, one root bit per stage
`default_nettype none

module rrr_sqrt #(
   parameter int XW  = 32,
   parameter int SBW = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [XW-1:0]           in_x,
   input  logic [SBW-1:0]          in_sb,
   output logic                    out_valid,
   output logic [(XW+1)/2-1:0]     out_root,
   output logic [SBW-1:0]          out_sb
);
   import rrr_pkg::*;

   localparam int SW = (XW + 1) / 2;
   localparam int TW = 2 * SW + 2;

   logic           valid_ff [SW];
   logic [SBW-1:0] sb_ff    [SW];
   logic [TW-1:0]  rem_ff   [SW];
   logic [SW-1:0]  root_ff  [SW];

   genvar k;
   for (k = 0; k < SW; k++) begin : g_stage
      localparam int B = SW - 1 - k;

      logic           valid_in;
      logic [SBW-1:0] sb_in;
      logic [TW-1:0]  rem_pv;
      logic [SW-1:0]  root_pv;
      logic [TW-1:0]  trial;
      logic           take;
      logic [TW-1:0]  rem_in;
      logic [SW-1:0]  root_in;

      if (k == 0) begin : g_first
         assign valid_in = in_valid;
         assign sb_in    = in_sb;
         assign rem_pv   = TW'(in_x);
         assign root_pv  = '0;
      end else begin : g_next
         assign valid_in = valid_ff[k-1];
         assign sb_in    = sb_ff[k-1];
         assign rem_pv   = rem_ff[k-1];
         assign root_pv  = root_ff[k-1];
      end

      always_comb begin
         trial   = (TW'(root_pv) << (B + 1)) | (TW'(1) << (2 * B));
         take    = (rem_pv >= trial);
         rem_in  = take ? (rem_pv - trial) : rem_pv;
         root_in = root_pv;
         root_in[B] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_in;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sb_ff[k]   <= sb_in;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign out_valid = valid_ff[SW-1];
   assign out_root  = root_ff[SW-1];
   assign out_sb    = sb_ff[SW-1];

endmodule

`default_nettype wire

// ----- rtl/ray_reflect_refract.sv -----
// top level: pipelined vector reflection and refraction unit; at default widths
// it has 5 fixed stages, 17 multiplier chunk stages, and one stage per root bit
// of the square root (85 by default)
// throughput one beat per cycle; the whole pipeline advances together and
// holds while a finished result waits on rsp_ch
// synchronous reset clears only the valid bits; data registers are not reset
`default_nettype none

module ray_reflect_refract #(
   parameter int COMP_WIDTH = rrr_pkg::COMP_WIDTH_DEF,
   parameter int FRAC_BITS  = rrr_pkg::FRAC_BITS_DEF
) (
   input  logic   clock,
   input  logic   reset,
   rrr_req_if.sink   req_ch,
   rrr_rsp_if.source rsp_ch
);
   import rrr_pkg::*;

   localparam int W    = COMP_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int ETW  = F + 2;
   localparam int EW   = ETW + 1;
   localparam int DW   = 2 * W + 2;
   localparam int MW   = DW + W;
   localparam int AW   = imax(W + 2 * F, MW + 1) + 1;
   localparam int PW   = AW + EW;
   localparam int QW   = 2 * PW;
   localparam int SQW  = QW + 2;
   localparam int XW   = imax(8 * F + 1, SQW) + 1;
   localparam int SW   = (XW + 1) / 2;
   localparam int NW   = SW + 1 + W;
   localparam int RW   = imax(PW + F, NW) + 1;
   localparam int SATW = imax(AW, RW);

   typedef struct packed {
      mode_type         mode;
      logic [ETW-1:0]   eta;
      logic [2:0][W-1:0] v;
      logic [2:0][W-1:0] n;
   } sb1_type;

   typedef struct packed {
      mode_type          mode;
      logic [2:0][W-1:0] n;
      logic [2:0][W-1:0] refl;
   } sb5_type;

   typedef struct packed {
      mode_type           mode;
      logic [2:0][W-1:0]  n;
      logic [2:0][W-1:0]  refl;
      logic [2:0][PW-1:0] p;
   } sb6_type;

   typedef struct packed {
      mode_type           mode;
      logic [2:0][W-1:0]  refl;
      logic [2:0][PW-1:0] p;
   } sb9_type;

   function automatic logic signed [W-1:0] sat_w(input logic signed [SATW-1:0] v);
      logic [SATW-W:0] hi;
      hi = v[SATW-1:W-1];
      if ((&hi) || !(|hi)) begin
         return v[W-1:0];
      end else if (v[SATW-1]) begin
         return {1'b1, {(W-1){1'b0}}};
      end else begin
         return {1'b0, {(W-1){1'b1}}};
      end
   endfunction

   logic en;
   logic valid10_ff;

   assign en           = !valid10_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // input register
   sb1_type sb0_in, sb0_ff;
   logic    valid0_ff;

   always_comb begin
      sb0_in.mode = mode_type'(req_ch.mode);
      sb0_in.eta  = req_ch.eta_ratio;
      sb0_in.v[0] = req_ch.incident_x;
      sb0_in.v[1] = req_ch.incident_y;
      sb0_in.v[2] = req_ch.incident_z;
      sb0_in.n[0] = req_ch.normal_x;
      sb0_in.n[1] = req_ch.normal_y;
      sb0_in.n[2] = req_ch.normal_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else if (en) begin
         valid0_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sb0_ff <= sb0_in;
      end
   end

   // v_i * n_i
   logic signed [W-1:0]   v0 [3];
   logic signed [W-1:0]   n0 [3];
   logic                  valid1;
   logic signed [2*W-1:0] pr1 [3];
   sb1_type               sb1;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         v0[l] = signed'(sb0_ff.v[l]);
         n0[l] = signed'(sb0_ff.n[l]);
      end
   end

   rrr_mul3 #(.AW(W), .BW(W), .SBW($bits(sb1_type))) u_dot_mul (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(valid0_ff), .in_a(v0), .in_b(n0), .in_sb(sb0_ff),
      .out_valid(valid1), .out_p(pr1), .out_sb(sb1)
   );

   // dot product
   logic signed [DW-1:0] d2_in, d2_ff;
   sb1_type              sb2_ff;
   logic                 valid2_ff;

   assign d2_in = DW'(pr1[0]) + DW'(pr1[1]) + DW'(pr1[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else if (en) begin
         valid2_ff <= valid1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d2_ff  <= d2_in;
         sb2_ff <= sb1;
      end
   end

   // d * n_i
   logic signed [DW-1:0] d3 [3];
   logic signed [W-1:0]  n2 [3];
   logic                 valid3;
   logic signed [MW-1:0] m3 [3];
   sb1_type              sb3;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         d3[l] = d2_ff;
         n2[l] = signed'(sb2_ff.n[l]);
      end
   end

   rrr_mul3 #(.AW(DW), .BW(W), .SBW($bits(sb1_type))) u_dn_mul (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(valid2_ff), .in_a(d3), .in_b(n2), .in_sb(sb2_ff),
      .out_valid(valid3), .out_p(m3), .out_sb(sb3)
   );

   // reflect result and refract pre-scale vector
   logic signed [AW-1:0] a4_in [3];
   logic signed [AW-1:0] a4_ff [3];
   sb5_type              sb4_in, sb4_ff;
   logic [ETW-1:0]       eta4_ff;
   logic                 valid4_ff;

   always_comb begin
      logic signed [AW-1:0] vs;
      logic signed [AW-1:0] mm;
      sb4_in.mode = sb3.mode;
      sb4_in.n    = sb3.n;
      for (int l = 0; l < 3; l++) begin
         vs = AW'(signed'(sb3.v[l])) <<< (2 * F);
         mm = AW'(m3[l]);
         a4_in[l] = (sb3.mode == MODE_REFRACT) ? (vs - mm) : (vs - (mm <<< 1));
         sb4_in.refl[l] = sat_w(SATW'(a4_in[l] >>> (2 * F)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
      end else if (en) begin
         valid4_ff <= valid3;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a4_ff   <= a4_in;
         sb4_ff  <= sb4_in;
         eta4_ff <= sb3.eta;
      end
   end

   // perp = eta * a
   logic signed [EW-1:0] eta5 [3];
   logic                 valid5;
   logic signed [PW-1:0] p5 [3];
   sb5_type              sb5;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         eta5[l] = signed'({1'b0, eta4_ff});
      end
   end

   rrr_mul3 #(.AW(AW), .BW(EW), .SBW($bits(sb5_type))) u_eta_mul (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(valid4_ff), .in_a(a4_ff), .in_b(eta5), .in_sb(sb4_ff),
      .out_valid(valid5), .out_p(p5), .out_sb(sb5)
   );

   // perp squared
   sb6_type              sb6_in;
   logic                 valid6;
   logic signed [QW-1:0] q6 [3];
   sb6_type              sb6;

   always_comb begin
      sb6_in.mode = sb5.mode;
      sb6_in.n    = sb5.n;
      sb6_in.refl = sb5.refl;
      for (int l = 0; l < 3; l++) begin
         sb6_in.p[l] = p5[l];
      end
   end

   rrr_mul3 #(.AW(PW), .BW(PW), .SBW($bits(sb6_type))) u_sq_mul (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(valid5), .in_a(p5), .in_b(p5), .in_sb(sb6_in),
      .out_valid(valid6), .out_p(q6), .out_sb(sb6)
   );

   // radicand |1 - |perp|^2|
   logic [XW-1:0] x7_in, x7_ff;
   sb6_type       sb7_ff;
   logic          valid7_ff;

   always_comb begin
      logic signed [SQW-1:0] sum;
      logic signed [XW-1:0]  xs;
      sum   = SQW'(q6[0]) + SQW'(q6[1]) + SQW'(q6[2]);
      xs    = (XW'(1) <<< (8 * F)) - XW'(sum);
      x7_in = xs[XW-1] ? -xs : xs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid7_ff <= 1'b0;
      end else if (en) begin
         valid7_ff <= valid6;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x7_ff  <= x7_in;
         sb7_ff <= sb6;
      end
   end

   // square root
   logic          valid8;
   logic [SW-1:0] root8;
   sb6_type       sb8;

   rrr_sqrt #(.XW(XW), .SBW($bits(sb6_type))) u_sqrt (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(valid7_ff), .in_x(x7_ff), .in_sb(sb7_ff),
      .out_valid(valid8), .out_root(root8), .out_sb(sb8)
   );

   // s * n_i
   logic signed [SW:0]   s9 [3];
   logic signed [W-1:0]  n8 [3];
   sb9_type              sb9_in;
   logic                 valid9;
   logic signed [NW-1:0] sn9 [3];
   sb9_type              sb9;

   always_comb begin
      sb9_in.mode = sb8.mode;
      sb9_in.refl = sb8.refl;
      sb9_in.p    = sb8.p;
      for (int l = 0; l < 3; l++) begin
         s9[l] = signed'({1'b0, root8});
         n8[l] = signed'(sb8.n[l]);
      end
   end

   rrr_mul3 #(.AW(SW + 1), .BW(W), .SBW($bits(sb9_type))) u_sn_mul (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(valid8), .in_a(s9), .in_b(n8), .in_sb(sb9_in),
      .out_valid(valid9), .out_p(sn9), .out_sb(sb9)
   );

   // final combine, scale, saturate and output register
   logic signed [W-1:0] out_in [3];
   logic signed [W-1:0] out_ff [3];

   always_comb begin
      logic signed [RW-1:0] r;
      for (int l = 0; l < 3; l++) begin
         r = (RW'(signed'(sb9.p[l])) <<< F) - RW'(sn9[l]);
         out_in[l] = (sb9.mode == MODE_REFRACT) ? sat_w(SATW'(r >>> (4 * F)))
                                                : signed'(sb9.refl[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid10_ff <= 1'b0;
      end else if (en) begin
         valid10_ff <= valid9;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid = valid10_ff;
   assign rsp_ch.out_x = out_ff[0];
   assign rsp_ch.out_y = out_ff[1];
   assign rsp_ch.out_z = out_ff[2];

endmodule

`default_nettype wire

// ----- rtl/rrr_check.sv -----
// port-level checker for the reflect/refract unit and its bind
`default_nettype none

module rrr_check #(
   parameter int W = rrr_pkg::COMP_WIDTH_DEF
) (
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input logic [W-1:0] out_x,
   input logic [W-1:0] out_y,
   input logic [W-1:0] out_z
);

   // no result right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a waiting result stalls the input side
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while result stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result beat dropped under stall");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(out_x) && $stable(out_y) && $stable(out_z)))
      else $error("result payload changed under stall");

endmodule

bind ray_reflect_refract rrr_check #(.W(COMP_WIDTH)) u_check (
   .clock    (clock),
   .reset    (reset),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .out_x    (rsp_ch.out_x),
   .out_y    (rsp_ch.out_y),
   .out_z    (rsp_ch.out_z)
);

`default_nettype wire

// ----- verif/tb_ray_reflect_refract.sv -----
// testbench for ray_reflect_refract: random and directed ray beats checked against an exact predictor
`default_nettype none

module tb_ray_reflect_refract;
   timeunit 1ns;
   timeprecision 1ps;

   import rrr_pkg::*;

   localparam int CW       = COMP_WIDTH_DEF;
   localparam int FB       = FRAC_BITS_DEF;
   localparam int LATENCY  = 107;
   localparam int WD_LIMIT = 4000;
   localparam int ONE      = 1 << FB;

   typedef logic signed [255:0] wide_type;
   typedef logic signed [CW-1:0] comp_type;

   typedef struct {
      mode_type      mode;
      comp_type      ix, iy, iz, nx, ny, nz;
      logic [FB+1:0] eta;
   } ray_hit_type;

   typedef struct {
      comp_type x, y, z;
   } ray_dir_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rrr_req_if #(.COMP_WIDTH(CW), .FRAC_BITS(FB)) req_ch ();
   rrr_rsp_if #(.COMP_WIDTH(CW)) rsp_ch ();

   ray_reflect_refract #(.COMP_WIDTH(CW), .FRAC_BITS(FB)) i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always #5 clock = ~clock;

   ray_hit_type pending_hits[$];
   ray_dir_type expected_dirs[$];
   int          phase = 0;
   int          errors = 0;
   int          quiet_cycles = 0;

   function automatic wide_type floor_sqrt(wide_type x);
      logic [255:0] root;
      logic [255:0] trial;
      root = '0;
      for (int b = 127; b >= 0; b--) begin
         trial = root | (256'd1 << b);
         if (trial * trial <= x) root = trial;
      end
      return wide_type'(root);
   endfunction

   function automatic comp_type clamp(wide_type r);
      wide_type hi, lo;
      hi = (wide_type'(1) <<< (CW - 1)) - 1;
      lo = -hi - 1;
      if (r > hi) r = hi;
      else if (r < lo) r = lo;
      return r[CW-1:0];
   endfunction

   function automatic ray_dir_type bend_ray(ray_hit_type h);
      wide_type    v[3], n[3], p[3];
      wide_type    d, c, eta, x, s, r;
      comp_type    o[3];
      ray_dir_type res;
      v[0] = h.ix; v[1] = h.iy; v[2] = h.iz;
      n[0] = h.nx; n[1] = h.ny; n[2] = h.nz;
      eta = {238'b0, h.eta};
      d = v[0] * n[0] + v[1] * n[1] + v[2] * n[2];
      if (h.mode == MODE_REFLECT) begin
         for (int i = 0; i < 3; i++) begin
            r = (v[i] <<< (2 * FB)) - (d + d) * n[i];
            o[i] = clamp(r >>> (2 * FB));
         end
      end else begin
         c = -d;
         for (int i = 0; i < 3; i++) p[i] = eta * ((v[i] <<< (2 * FB)) + c * n[i]);
         x = (wide_type'(1) <<< (8 * FB)) - (p[0] * p[0] + p[1] * p[1] + p[2] * p[2]);
         if (x < 0) x = -x;
         s = floor_sqrt(x);
         for (int i = 0; i < 3; i++) begin
            r = (p[i] <<< FB) - s * n[i];
            o[i] = clamp(r >>> (4 * FB));
         end
      end
      res.x = o[0]; res.y = o[1]; res.z = o[2];
      return res;
   endfunction

   task automatic report(string what, comp_type got, comp_type exp);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
      errors++;
   endtask

   // request driver
   always @(posedge clock) begin
      ray_hit_type h;
      logic        send;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            h.mode = mode_type'(req_ch.mode);
            h.ix = req_ch.incident_x; h.iy = req_ch.incident_y; h.iz = req_ch.incident_z;
            h.nx = req_ch.normal_x; h.ny = req_ch.normal_y; h.nz = req_ch.normal_z;
            h.eta = req_ch.eta_ratio;
            expected_dirs.push_back(bend_ray(h));
         end
         if (!req_ch.valid || req_ch.ready) begin
            send = pending_hits.size() > 0;
            if (phase == 1 && $urandom_range(99) < 85) send = 1'b0;
            if (phase == 3 && $urandom_range(99) < 6) send = 1'b0;
            if (send) begin
               h = pending_hits.pop_front();
               req_ch.mode <= h.mode;
               req_ch.incident_x <= h.ix; req_ch.incident_y <= h.iy;
               req_ch.incident_z <= h.iz;
               req_ch.normal_x <= h.nx; req_ch.normal_y <= h.ny; req_ch.normal_z <= h.nz;
               req_ch.eta_ratio <= h.eta;
            end
            req_ch.valid <= send;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      ray_dir_type e;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_dirs.size() == 0) begin
               $display("unexpected beat x=%0d y=%0d z=%0d at %0t",
                        rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z, $realtime);
               errors++;
            end else begin
               e = expected_dirs.pop_front();
               if (rsp_ch.out_x !== e.x) report("out_x", rsp_ch.out_x, e.x);
               if (rsp_ch.out_y !== e.y) report("out_y", rsp_ch.out_y, e.y);
               if (rsp_ch.out_z !== e.z) report("out_z", rsp_ch.out_z, e.z);
            end
         end
         case (phase)
            2: rsp_ch.ready <= $urandom_range(99) >= 85;
            3: rsp_ch.ready <= $urandom_range(99) >= 6;
            default: rsp_ch.ready <= 1'b1;
         endcase
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
         $display("tb_ray_reflect_refract NOT OK");
         $finish;
      end
   end

   function automatic comp_type rnd_comp(bit full);
      if (full) return comp_type'($urandom);
      return comp_type'(int'($urandom_range(2 * ONE)) - ONE);
   endfunction

   function automatic ray_hit_type rnd_hit();
      ray_hit_type h;
      bit          full;
      full = $urandom_range(9) < 2;
      h.mode = mode_type'($urandom_range(1));
      h.ix = rnd_comp(full); h.iy = rnd_comp(full); h.iz = rnd_comp(full);
      h.nx = rnd_comp(full); h.ny = rnd_comp(full); h.nz = rnd_comp(full);
      h.eta = full ? (FB + 2)'($urandom) : (FB + 2)'($urandom_range(ONE / 2, 3 * ONE / 2));
      return h;
   endfunction

   function automatic ray_hit_type mk(mode_type m, int ix, int iy, int iz,
                                      int nx, int ny, int nz, int eta);
      ray_hit_type h;
      h.mode = m;
      h.ix = comp_type'(ix); h.iy = comp_type'(iy); h.iz = comp_type'(iz);
      h.nx = comp_type'(nx); h.ny = comp_type'(ny); h.nz = comp_type'(nz);
      h.eta = (FB + 2)'(eta);
      return h;
   endfunction

   initial begin
      int cmax, cmin, emax;
      cmax = (1 << (CW - 1)) - 1;
      cmin = -(1 << (CW - 1));
      emax = (1 << (FB + 2)) - 1;
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_REFLECT;
      req_ch.incident_x = '0; req_ch.incident_y = '0; req_ch.incident_z = '0;
      req_ch.normal_x = '0; req_ch.normal_y = '0; req_ch.normal_z = '0;
      req_ch.eta_ratio = '0;
      rsp_ch.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, both modes, negative radicand, saturation
      for (int m = 0; m < 2; m++) begin
         pending_hits.push_back(mk(mode_type'(m), 0, 0, 0, 0, 0, 0, 0));
         pending_hits.push_back(mk(mode_type'(m), cmax, cmax, cmax, cmax, cmax, cmax, emax));
         pending_hits.push_back(mk(mode_type'(m), cmin, cmin, cmin, cmin, cmin, cmin, emax));
         pending_hits.push_back(mk(mode_type'(m), cmax, cmin, cmax, cmin, cmax, cmin, 0));
         pending_hits.push_back(mk(mode_type'(m), 0, -ONE, 0, 0, ONE, 0, ONE));
         pending_hits.push_back(mk(mode_type'(m), ONE / 2, -ONE / 2, 0, 0, ONE, 0, ONE));
         pending_hits.push_back(mk(mode_type'(m), 46341, -46341, 0, 0, ONE, 0, 3 * ONE / 2));
         pending_hits.push_back(mk(mode_type'(m), 60000, -20000, 1000, 0, 0, ONE, 2 * ONE));
         pending_hits.push_back(mk(mode_type'(m), ONE, ONE, ONE, -ONE, 0, ONE, ONE / 3));
         pending_hits.push_back(mk(mode_type'(m), 3 * ONE, -2 * ONE, ONE, ONE, ONE, ONE, emax));
      end
      for (int p = 0; p < 4; p++) begin
         for (int k = 0; k < 135; k++) pending_hits.push_back(rnd_hit());
         phase = p;
         wait (pending_hits.size() == 0 && !req_ch.valid && expected_dirs.size() == 0);
      end
      repeat (LATENCY + 50) @(posedge clock);
      if (errors == 0 && expected_dirs.size() == 0) begin
         $display("tb_ray_reflect_refract OK");
      end else begin
         $display("tb_ray_reflect_refract NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
